// File: rtl/core/business_day_calendar_core_assert.svh
// Assertion macros used by the port-level checker of the business-day calendar.
// No dependencies; each macro expands to one clocked concurrent assertion.
`ifndef BUSINESS_DAY_CALENDAR_CORE_ASSERT_SVH
`define BUSINESS_DAY_CALENDAR_CORE_ASSERT_SVH

// Implication that is checked at every rising edge outside reset.
`define BDC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bdc_pkg.sv
// Package of the business-day calendar: constants, codes, types and helpers.
// No dependencies; used by the top level, controller and datapath by scoped names.
package bdc_pkg;

    localparam int TABLE_DEPTH   = 32;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int SEARCH_LIMIT  = 366;
    localparam int GUARD_W       = $clog2(SEARCH_LIMIT + 1);
    localparam int MAX_DAY_COUNT = 15;
    localparam int CNT_W         = 4;
    localparam int YEAR_W        = 14;
    localparam int MONTH_W       = 4;
    localparam int DAY_W         = 5;
    localparam int REGION_W      = 2;
    localparam int YEAR_MAX      = 9999;

    typedef enum logic [2:0] {
        CMD_ADD      = 3'd0,
        CMD_REMOVE   = 3'd1,
        CMD_QUERY    = 3'd2,
        CMD_ADD_DAYS = 3'd3,
        CMD_PREV_DAY = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_MODK,
        ST_CLAMP,
        ST_ZSUM,
        ST_ZMOD,
        ST_ADD,
        ST_REMOVE,
        ST_STEP,
        ST_CHECK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic div;
        logic modk;
        logic clamp;
        logic zsum;
        logic zmod;
        logic add;
        logic remove;
        logic step_first;
        logic step_next;
        logic count_dec;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic cnt_zero;
        logic cnt_last;
        logic search_done;
        logic out_free;
    } dp_stat_t;

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] n;
        begin
            unique case (m)
                4'd2:                      n = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
                default:                   n = 5'd31;
            endcase
            return n;
        end
    endfunction

    function automatic logic [5:0] zeller_month_term(input logic [MONTH_W-1:0] mz);
        logic [5:0] t;
        begin
            unique case (mz)
                4'd3:    t = 6'd10;
                4'd4:    t = 6'd13;
                4'd5:    t = 6'd15;
                4'd6:    t = 6'd18;
                4'd7:    t = 6'd20;
                4'd8:    t = 6'd23;
                4'd9:    t = 6'd26;
                4'd10:   t = 6'd28;
                4'd11:   t = 6'd31;
                4'd12:   t = 6'd33;
                4'd13:   t = 6'd36;
                4'd14:   t = 6'd39;
                default: t = 6'd0;
            endcase
            return t;
        end
    endfunction

endpackage

// File: rtl/core/business_day_calendar_core.sv
// Top level of the business-day calendar: stream ports, APB registers,
// controller and datapath. Depends on bdc_pkg, bdc_ctrl and bdc_dp.
//
// One command item is taken at a time. Every command passes through the states
// DIV, MODK, CLAMP, ZSUM and ZMOD: a reciprocal multiply and a remainder split
// the year, the day is clamped and the weekday comes from a Zeller evaluation
// (sum, then modulo 7). Query and the unknown codes then go to the output state;
// add and remove take their own state first. Each forward business day steps the
// date and keeps stepping while it checks, since the date sequencer advances one
// day a cycle while all 32 holiday entries are matched in parallel; a search stops
// after at most 366 extra days. The previous business day works the same way once.
// The result waits in an output register, so the next item is taken while it
// waits. The holiday table is cleared at once by reset.
module business_day_calendar_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // year[13:0], month[17:14], day[22:18], region[24:23], early[25],
    // day_count[29:26], zero fill
    input  logic [31:0] s_axis_tdata,
    // command[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_year[13:0], out_month[17:14], out_day[22:18], weekday[25:23],
    // is_holiday[26], is_early[27], is_business[28], status[29], zero fill
    output logic [31:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              weekend_skip_reg;
    logic [1:0]        home_region_reg;
    bdc_pkg::dp_cmd_t  cmd;
    bdc_pkg::dp_stat_t stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weekend_skip_reg <= 1'b1;
            home_region_reg  <= 2'd0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2])
            begin
                home_region_reg <= pwdata[1:0];
            end
            else
            begin
                weekend_skip_reg <= pwdata[0];
            end
        end
    end

    assign prdata = paddr[2] ? {30'd0, home_region_reg} : {31'd0, weekend_skip_reg};

    bdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bdc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_command   (s_axis_tuser),
        .in_data      (s_axis_tdata[29:0]),
        .weekend_skip (weekend_skip_reg),
        .home_region  (home_region_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata)
    );

endmodule

// File: rtl/core/bdc_ctrl.sv
// Controller state machine of the business-day calendar.
// Depends on bdc_pkg; drives the datapath by command and reads its status.
module bdc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bdc_pkg::dp_stat_t stat,
    output bdc_pkg::dp_cmd_t  cmd
);

    bdc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            bdc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = bdc_pkg::ST_DIV;
                end
            end
            bdc_pkg::ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = bdc_pkg::ST_MODK;
            end
            bdc_pkg::ST_MODK:
            begin
                cmd.modk   = 1'b1;
                state_next = bdc_pkg::ST_CLAMP;
            end
            bdc_pkg::ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = bdc_pkg::ST_ZSUM;
            end
            bdc_pkg::ST_ZSUM:
            begin
                cmd.zsum   = 1'b1;
                state_next = bdc_pkg::ST_ZMOD;
            end
            bdc_pkg::ST_ZMOD:
            begin
                cmd.zmod = 1'b1;
                unique case (stat.cmd)
                    bdc_pkg::CMD_ADD:      state_next = bdc_pkg::ST_ADD;
                    bdc_pkg::CMD_REMOVE:   state_next = bdc_pkg::ST_REMOVE;
                    bdc_pkg::CMD_ADD_DAYS: state_next = stat.cnt_zero ? bdc_pkg::ST_OUT
                                                                      : bdc_pkg::ST_STEP;
                    bdc_pkg::CMD_PREV_DAY: state_next = bdc_pkg::ST_STEP;
                    default:               state_next = bdc_pkg::ST_OUT;
                endcase
            end
            bdc_pkg::ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = bdc_pkg::ST_OUT;
            end
            bdc_pkg::ST_REMOVE:
            begin
                cmd.remove = 1'b1;
                state_next = bdc_pkg::ST_OUT;
            end
            bdc_pkg::ST_STEP:
            begin
                cmd.step_first = 1'b1;
                state_next     = bdc_pkg::ST_CHECK;
            end
            bdc_pkg::ST_CHECK:
            begin
                if (stat.search_done)
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = stat.cnt_last ? bdc_pkg::ST_OUT : bdc_pkg::ST_STEP;
                end
                else
                begin
                    cmd.step_next = 1'b1;
                end
            end
            bdc_pkg::ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = bdc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/bdc_dp.sv
// Datapath of the business-day calendar: date registers, holiday table,
// weekday arithmetic and the output register. Depends on bdc_pkg.
module bdc_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  bdc_pkg::dp_cmd_t  cmd,
    output bdc_pkg::dp_stat_t stat,
    input  logic [2:0]        in_command,
    input  logic [29:0]       in_data,
    input  logic              weekend_skip,
    input  logic [1:0]        home_region,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_data
);

    localparam int D = bdc_pkg::TABLE_DEPTH;

    logic [bdc_pkg::YEAR_W-1:0]   cur_y_reg;
    logic [bdc_pkg::MONTH_W-1:0]  cur_m_reg;
    logic [bdc_pkg::DAY_W-1:0]    cur_d_reg;
    logic [bdc_pkg::REGION_W-1:0] region_reg;
    logic                         early_reg;
    bdc_pkg::cmd_t                cmd_reg;
    logic [bdc_pkg::CNT_W-1:0]    cnt_reg;
    logic                         fwd_reg;
    logic [6:0]                   yj_reg;
    logic [6:0]                   yk_reg;
    logic [9:0]                   h_reg;
    logic [2:0]                   wd_reg;
    logic [bdc_pkg::GUARD_W-1:0]  guard_reg;
    logic                         status_reg;

    logic [D-1:0]                 ent_valid_reg;
    logic [bdc_pkg::YEAR_W-1:0]   ent_y_reg [D];
    logic [bdc_pkg::MONTH_W-1:0]  ent_m_reg [D];
    logic [bdc_pkg::DAY_W-1:0]    ent_d_reg [D];
    logic [bdc_pkg::REGION_W-1:0] ent_r_reg [D];
    logic [D-1:0]                 ent_e_reg;

    logic                         out_valid_reg;
    logic [31:0]                  out_data_reg;

    logic [bdc_pkg::YEAR_W-1:0]   raw_y;
    logic [bdc_pkg::MONTH_W-1:0]  raw_m;
    logic [bdc_pkg::CNT_W-1:0]    raw_cnt;
    logic [26:0]                  div_prod;
    logic [21:0]                  mod_prod;
    logic [6:0]                   mod_q;
    logic [9:0]                   mod_r;
    logic                         leap;
    logic [bdc_pkg::DAY_W-1:0]    dim;
    logic [6:0]                   zk, zj;
    logic [bdc_pkg::MONTH_W-1:0]  mz;
    logic [D-1:0]                 hit;
    logic                         any_hit, hit_early, has_free, business;
    logic [bdc_pkg::IDX_W-1:0]    free_idx;
    logic [bdc_pkg::YEAR_W-1:0]   st_y;
    logic [bdc_pkg::MONTH_W-1:0]  st_m;
    logic [bdc_pkg::DAY_W-1:0]    st_d;
    logic [6:0]                   st_yj, st_yk;
    logic [2:0]                   st_wd;

    assign raw_y   = in_data[13:0];
    assign raw_m   = in_data[17:14];
    assign raw_cnt = in_data[29:26];

    assign div_prod = {13'd0, cur_y_reg} * 27'd5243;
    assign mod_prod = {12'd0, h_reg} * 22'd2341;
    assign mod_q    = mod_prod[20:14];
    assign mod_r    = h_reg - 10'({3'd0, mod_q} * 10'd7);

    assign leap = (yk_reg == 7'd0) ? (yj_reg[1:0] == 2'd0) : (yk_reg[1:0] == 2'd0);
    assign dim  = bdc_pkg::days_in_month(cur_m_reg, leap);

    always_comb
    begin
        zk = yk_reg;
        zj = yj_reg;
        mz = cur_m_reg;
        if (cur_m_reg < 4'd3)
        begin
            mz = cur_m_reg + 4'd12;
            if (yk_reg == 7'd0)
            begin
                zk = 7'd99;
                zj = yj_reg - 7'd1;
            end
            else
            begin
                zk = yk_reg - 7'd1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            hit[i] = ent_valid_reg[i] && ent_y_reg[i] == cur_y_reg && ent_m_reg[i] == cur_m_reg
                     && ent_d_reg[i] == cur_d_reg && ent_r_reg[i] == region_reg;
        end
    end

    assign any_hit   = |hit;
    assign hit_early = |(hit & ent_e_reg);
    assign has_free  = ~&ent_valid_reg;
    assign business  = !(weekend_skip && (wd_reg == 3'd0 || wd_reg == 3'd6)) && !any_hit;

    always_comb
    begin
        free_idx = '0;
        for (int i = D - 1; i >= 0; i--)
        begin
            if (!ent_valid_reg[i])
            begin
                free_idx = bdc_pkg::IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        st_y  = cur_y_reg;
        st_m  = cur_m_reg;
        st_d  = cur_d_reg;
        st_yj = yj_reg;
        st_yk = yk_reg;
        st_wd = wd_reg;
        if (fwd_reg)
        begin
            if (!(cur_y_reg >= 14'(bdc_pkg::YEAR_MAX) && cur_m_reg == 4'd12
                  && cur_d_reg == 5'd31))
            begin
                st_wd = (wd_reg == 3'd6) ? 3'd0 : wd_reg + 3'd1;
                if (cur_d_reg >= dim)
                begin
                    st_d = 5'd1;
                    if (cur_m_reg == 4'd12)
                    begin
                        st_m = 4'd1;
                        st_y = cur_y_reg + 14'd1;
                        if (yk_reg == 7'd99)
                        begin
                            st_yk = 7'd0;
                            st_yj = yj_reg + 7'd1;
                        end
                        else
                        begin
                            st_yk = yk_reg + 7'd1;
                        end
                    end
                    else
                    begin
                        st_m = cur_m_reg + 4'd1;
                    end
                end
                else
                begin
                    st_d = cur_d_reg + 5'd1;
                end
            end
        end
        else
        begin
            if (!(cur_y_reg <= 14'd1 && cur_m_reg == 4'd1 && cur_d_reg == 5'd1))
            begin
                st_wd = (wd_reg == 3'd0) ? 3'd6 : wd_reg - 3'd1;
                if (cur_d_reg <= 5'd1)
                begin
                    if (cur_m_reg <= 4'd1)
                    begin
                        st_m = 4'd12;
                        st_d = 5'd31;
                        st_y = cur_y_reg - 14'd1;
                        if (yk_reg == 7'd0)
                        begin
                            st_yk = 7'd99;
                            st_yj = yj_reg - 7'd1;
                        end
                        else
                        begin
                            st_yk = yk_reg - 7'd1;
                        end
                    end
                    else
                    begin
                        st_m = cur_m_reg - 4'd1;
                        st_d = bdc_pkg::days_in_month(cur_m_reg - 4'd1, leap);
                    end
                end
                else
                begin
                    st_d = cur_d_reg - 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_y_reg  <= (raw_y == 14'd0) ? 14'd1 :
                          (raw_y > 14'(bdc_pkg::YEAR_MAX)) ? 14'(bdc_pkg::YEAR_MAX) : raw_y;
            cur_m_reg  <= (raw_m == 4'd0) ? 4'd1 : (raw_m > 4'd12) ? 4'd12 : raw_m;
            cur_d_reg  <= in_data[22:18];
            early_reg  <= in_data[25];
            cmd_reg    <= bdc_pkg::cmd_t'(in_command);
            fwd_reg    <= (bdc_pkg::cmd_t'(in_command) == bdc_pkg::CMD_ADD_DAYS);
            status_reg <= 1'b0;
            if (bdc_pkg::cmd_t'(in_command) == bdc_pkg::CMD_ADD_DAYS
                || bdc_pkg::cmd_t'(in_command) == bdc_pkg::CMD_PREV_DAY)
            begin
                region_reg <= home_region;
            end
            else
            begin
                region_reg <= in_data[24:23];
            end
            if (bdc_pkg::cmd_t'(in_command) == bdc_pkg::CMD_PREV_DAY)
            begin
                cnt_reg <= bdc_pkg::CNT_W'(1);
            end
            else if (raw_cnt > bdc_pkg::CNT_W'(bdc_pkg::MAX_DAY_COUNT))
            begin
                cnt_reg <= bdc_pkg::CNT_W'(bdc_pkg::MAX_DAY_COUNT);
            end
            else
            begin
                cnt_reg <= raw_cnt;
            end
        end
        if (cmd.div)
        begin
            yj_reg <= div_prod[25:19];
        end
        if (cmd.modk)
        begin
            yk_reg <= 7'(cur_y_reg - 14'({7'd0, yj_reg} * 14'd100));
        end
        if (cmd.clamp)
        begin
            cur_d_reg <= (cur_d_reg == 5'd0) ? 5'd1 : (cur_d_reg > dim) ? dim : cur_d_reg;
        end
        if (cmd.zsum)
        begin
            h_reg <= {5'd0, cur_d_reg} + {4'd0, bdc_pkg::zeller_month_term(mz)}
                     + {3'd0, zk} + {5'd0, zk[6:2]} + {5'd0, zj[6:2]}
                     + {1'b0, zj, 2'b00} + {3'd0, zj};
        end
        if (cmd.zmod)
        begin
            wd_reg <= (mod_r == 10'd0) ? 3'd6 : 3'(mod_r - 10'd1);
        end
        if (cmd.step_first || cmd.step_next)
        begin
            cur_y_reg <= st_y;
            cur_m_reg <= st_m;
            cur_d_reg <= st_d;
            yj_reg    <= st_yj;
            yk_reg    <= st_yk;
            wd_reg    <= st_wd;
            guard_reg <= cmd.step_first ? '0 : guard_reg + bdc_pkg::GUARD_W'(1);
        end
        if (cmd.count_dec)
        begin
            cnt_reg <= cnt_reg - bdc_pkg::CNT_W'(1);
        end
        if (cmd.add && !any_hit && !has_free)
        begin
            status_reg <= 1'b1;
        end
        if (cmd.add)
        begin
            if (any_hit)
            begin
                ent_e_reg <= ent_e_reg | (hit & {D{early_reg}});
            end
            else if (has_free)
            begin
                ent_y_reg[free_idx] <= cur_y_reg;
                ent_m_reg[free_idx] <= cur_m_reg;
                ent_d_reg[free_idx] <= cur_d_reg;
                ent_r_reg[free_idx] <= region_reg;
                ent_e_reg[free_idx] <= early_reg;
            end
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {2'b00, status_reg, business, hit_early, any_hit, wd_reg,
                             cur_d_reg, cur_m_reg, cur_y_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.add && !any_hit && has_free)
            begin
                ent_valid_reg[free_idx] <= 1'b1;
            end
            if (cmd.remove)
            begin
                ent_valid_reg <= ent_valid_reg & ~hit;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.cmd         = cmd_reg;
    assign stat.cnt_zero    = (cnt_reg == '0);
    assign stat.cnt_last    = (cnt_reg == bdc_pkg::CNT_W'(1));
    assign stat.search_done = business || guard_reg == bdc_pkg::GUARD_W'(bdc_pkg::SEARCH_LIMIT);
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/core/bdc_checker.sv
// Port-level checker of the business-day calendar, bound to the top level.
// Depends on business_day_calendar_core_assert.svh.
`include "business_day_calendar_core_assert.svh"

module bdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    `BDC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "Stalled result item changed")
    `BDC_ASSERT_IMPL(a_weekday, clk, rst_n, m_axis_tvalid, m_axis_tdata[25:23] != 3'd7, "Weekday out of range")
    `BDC_ASSERT_IMPL(a_early_hol, clk, rst_n, m_axis_tvalid && m_axis_tdata[27], m_axis_tdata[26], "Early close without holiday")
    `BDC_ASSERT_IMPL(a_hol_nobiz, clk, rst_n, m_axis_tvalid && m_axis_tdata[26], !m_axis_tdata[28], "Holiday reported as business day")

endmodule

bind business_day_calendar_core bdc_checker u_bdc_checker (.*);
